FILE: src/mss_pkg.sv
package mss_pkg;

  localparam int unsigned SampleW  = 10;
  localparam int unsigned CountW   = 16;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned LevelW   = 3;
  localparam int unsigned CfgDataW = 40;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned NumSteps = 5;
  localparam int unsigned StepSecW = 3;
  localparam int unsigned SumW     = 5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LOAD_THRESHOLD = 2'd0,
    REG_RUN_SECONDS    = 2'd1,
    REG_LEVEL_BOUNDS   = 2'd2,
    REG_DUTY_STEPS     = 2'd3
  } cfg_idx_t;

  localparam logic [SampleW-1:0]  LoadThresholdReset = 10'd200;
  localparam logic [CountW-1:0]   RunSecondsReset    = 16'd50;
  localparam logic [CfgDataW-1:0] LevelBoundsReset   = 40'd1010114898440;
  localparam logic [CfgDataW-1:0] DutyStepsReset     = 40'd275197265153;

  localparam logic [LevelW-1:0] LevelMax = 3'd4;

  // seconds spent on each duty step, one row per ramp level
  localparam logic [StepSecW-1:0] STEP_SECS [NumSteps][NumSteps] = '{
    '{3'd3, 3'd3, 3'd3, 3'd5, 3'd3},
    '{3'd2, 3'd2, 3'd2, 3'd5, 3'd2},
    '{3'd2, 3'd2, 3'd2, 3'd2, 3'd2},
    '{3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
  };

  typedef struct packed {
    logic [SampleW-1:0]  load_threshold;
    logic [CountW-1:0]   run_seconds;
    logic [CfgDataW-1:0] level_bounds;
    logic [CfgDataW-1:0] duty_steps;
  } cfg_t;

  typedef struct packed {
    logic              running;
    logic [LevelW-1:0] ramp_level;
    logic [CountW-1:0] seconds_count;
    logic [DutyW-1:0]  duty_now;
    logic [LevelW-1:0] led_shown;
  } seq_state_t;

endpackage

FILE: src/mss_if.sv
interface mss_in_if;
  import mss_pkg::*;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] ramp_pot_sample;
  logic [SampleW-1:0] load_sample;
  modport source (output valid, ramp_pot_sample, load_sample, input ready);
  modport sink   (input valid, ramp_pot_sample, load_sample, output ready);
endinterface

interface mss_out_if;
  import mss_pkg::*;
  logic              valid;
  logic              ready;
  logic [DutyW-1:0]  pwm_duty;
  logic              pwm_enable;
  logic [LevelW-1:0] led_level;
  logic [CountW-1:0] seconds_run;
  modport source (output valid, pwm_duty, pwm_enable, led_level, seconds_run, input ready);
  modport sink   (input valid, pwm_duty, pwm_enable, led_level, seconds_run, output ready);
endinterface

FILE: src/mss_cfg_regs.sv
module mss_cfg_regs
  import mss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.load_threshold <= LoadThresholdReset;
      cfg_r.run_seconds    <= RunSecondsReset;
      cfg_r.level_bounds   <= LevelBoundsReset;
      cfg_r.duty_steps     <= DutyStepsReset;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        REG_LOAD_THRESHOLD: cfg_r.load_threshold <= cfg_wdata[SampleW-1:0];
        REG_RUN_SECONDS:    cfg_r.run_seconds    <= cfg_wdata[CountW-1:0];
        REG_LEVEL_BOUNDS:   cfg_r.level_bounds   <= cfg_wdata;
        REG_DUTY_STEPS:     cfg_r.duty_steps     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: src/mss_step_logic.sv
module mss_step_logic
  import mss_pkg::*;
(
  input  cfg_t               cfg,
  input  seq_state_t         state,
  input  logic [SampleW-1:0] ramp_pot_sample,
  input  logic [SampleW-1:0] load_sample,
  output seq_state_t         state_nxt
);

  logic [LevelW-1:0] quant_level;
  logic [LevelW-1:0] row;
  logic [SumW-1:0]   sums [NumSteps-1];
  logic [LevelW-1:0] step_idx;
  logic [CountW-1:0] cnt_inc;
  seq_state_t        st;

  // first bound the sample lies below gives the level
  always_comb begin
    quant_level = LevelMax;
    for (int k = NumSteps - 2; k >= 0; k--) begin
      if (ramp_pot_sample < cfg.level_bounds[k*SampleW +: SampleW]) begin
        quant_level = LevelW'(k);
      end
    end
  end

  assign row     = (state.ramp_level > LevelMax) ? LevelMax : state.ramp_level;
  assign cnt_inc = state.seconds_count + CountW'(1);

  // running sums over the selected row, first one above the counter picks the step
  always_comb begin
    sums[0] = SumW'(STEP_SECS[row][0]);
    for (int k = 1; k < NumSteps - 1; k++) begin
      sums[k] = sums[k-1] + SumW'(STEP_SECS[row][k]);
    end
    step_idx = LevelMax;
    for (int k = NumSteps - 2; k >= 0; k--) begin
      if (cnt_inc < CountW'(sums[k])) begin
        step_idx = LevelW'(k);
      end
    end
  end

  always_comb begin
    st = state;
    if (!state.running) begin
      st.ramp_level = quant_level;
      st.led_shown  = quant_level;
      if (load_sample < cfg.load_threshold) begin
        st.running = 1'b1;
      end
    end else begin
      st.seconds_count = cnt_inc;
      st.duty_now      = cfg.duty_steps[step_idx*DutyW +: DutyW];
      st.led_shown     = step_idx;
    end
    if (st.seconds_count >= cfg.run_seconds) begin
      st.running       = 1'b0;
      st.seconds_count = '0;
      st.duty_now      = '0;
    end
    state_nxt = st;
  end

endmodule

FILE: src/motor_soft_start_sequencer_core.sv
// channel  | dir | handshake          | payload
// in_ch    | in  | valid/ready        | ramp_pot_sample, load_sample (one tick)
// out_ch   | out | valid/ready        | pwm_duty, pwm_enable, led_level, seconds_run
// cfg_*    | in  | cfg_we, no ready   | cfg_idx selects register, cfg_wdata 40 bit
//
// one request per cycle sustained while results are taken: a tick is held in the input
// register, the step logic updates the sequencer state and loads the result register
// result valid once the result register loads; a stalled result holds the tick back
// rst_n is synchronous; state and config return to their reset values
// a stalled result holds the input register, which then holds the input side
module motor_soft_start_sequencer_core
  import mss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  mss_in_if.sink              in_ch,
  mss_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t cfg;

  // input register
  logic               in_v_r;
  logic [SampleW-1:0] in_tcs_r;
  logic [SampleW-1:0] in_load_r;

  // sequencer state and result register
  seq_state_t        state_r;
  seq_state_t        state_nxt;
  logic              out_v_r;
  logic [DutyW-1:0]  out_duty_r;
  logic              out_en_r;
  logic [LevelW-1:0] out_led_r;
  logic [CountW-1:0] out_secs_r;

  logic advance;
  logic in_take;

  mss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mss_step_logic u_step (
    .cfg             (cfg),
    .state           (state_r),
    .ramp_pot_sample (in_tcs_r),
    .load_sample     (in_load_r),
    .state_nxt       (state_nxt)
  );

  // the held tick moves on whenever the result slot is free or being drained
  assign advance      = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (advance) begin
        state_r <= state_nxt;
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_tcs_r  <= in_ch.ramp_pot_sample;
      in_load_r <= in_ch.load_sample;
    end
    if (advance) begin
      out_duty_r <= state_nxt.duty_now;
      out_en_r   <= state_nxt.running;
      out_led_r  <= state_nxt.led_shown;
      out_secs_r <= state_nxt.seconds_count;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.pwm_duty    = out_duty_r;
  assign out_ch.pwm_enable  = out_en_r;
  assign out_ch.led_level   = out_led_r;
  assign out_ch.seconds_run = out_secs_r;

endmodule

FILE: tb/tb_motor_soft_start_sequencer_core.sv
`timescale 1ns / 1ps

module tb_motor_soft_start_sequencer_core;
  import mss_pkg::*;

  // one tick request as it sits on the input channel
  typedef struct packed {
    logic [SampleW-1:0] ramp_pot;
    logic [SampleW-1:0] load;
  } tick_t;

  // one result, fields in port order
  typedef struct packed {
    logic [DutyW-1:0]  duty;
    logic              enable;
    logic [LevelW-1:0] led;
    logic [CountW-1:0] secs;
  } motor_out_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // channel drive, known from time zero
  logic  tick_valid = 1'b0;
  tick_t tick_bus   = '0;
  logic  take_ready = 1'b0;

  mss_in_if  in_ch ();
  mss_out_if out_ch ();

  assign in_ch.valid           = tick_valid;
  assign in_ch.ramp_pot_sample = tick_bus.ramp_pot;
  assign in_ch.load_sample     = tick_bus.load;
  assign out_ch.ready          = take_ready;

  motor_soft_start_sequencer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the register file, starts at the reset values
  logic [SampleW-1:0]  thr_reg    = 10'd200;
  logic [CountW-1:0]   run_reg    = 16'd50;
  logic [CfgDataW-1:0] bounds_reg = {10'd940, 10'd760, 10'd650, 10'd520};
  logic [CfgDataW-1:0] duties_reg = {8'h40, 8'h13, 8'h09, 8'h05, 8'h01};

  // shadow sequencer state
  logic              motor_on = 1'b0;
  logic [LevelW-1:0] ramp_lvl = '0;
  logic [CountW-1:0] sec_cnt  = '0;
  logic [DutyW-1:0]  duty_cur = '0;
  logic [LevelW-1:0] led_cur  = '0;

  // seconds per duty step, row picked by the ramp level
  int ramp_secs [5][5] = '{
    '{3, 3, 3, 5, 3},
    '{2, 2, 2, 5, 2},
    '{2, 2, 2, 2, 2},
    '{1, 1, 1, 1, 1},
    '{0, 0, 0, 0, 0}
  };

  tick_t      pending_ticks [$];
  motor_out_t expected_outs [$];

  int bad_count     = 0;
  int results_taken = 0;
  int hold_left     = 0;
  bit steady        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // advance the shadow sequencer by one tick and return its result
  function automatic motor_out_t advance_motor(tick_t t);
    int  k;
    int  row;
    int  sum;
    int  step;
    bit  found;
    if (!motor_on) begin
      // idle: first bound the sample lies below picks the level, else top level
      ramp_lvl = 3'd4;
      found = 1'b0;
      for (k = 0; k < 4; k++) begin
        if (!found && t.ramp_pot < bounds_reg[10*k +: 10]) begin
          ramp_lvl = 3'(k);
          found = 1'b1;
        end
      end
      led_cur = ramp_lvl;
    end else begin
      // running: count, then walk the running sums of the selected row
      sec_cnt = sec_cnt + 1'b1;
      row = (ramp_lvl > 3'd4) ? 4 : int'(ramp_lvl);
      sum = 0;
      step = 4;
      found = 1'b0;
      for (k = 0; k < 4; k++) begin
        if (!found) begin
          sum += ramp_secs[row][k];
          if (int'(sec_cnt) < sum) begin
            step = k;
            found = 1'b1;
          end
        end
      end
      duty_cur = duties_reg[8*step +: 8];
      led_cur = 3'(step);
    end
    // a start keeps the old duty until the next tick
    if (!motor_on && t.load < thr_reg) motor_on = 1'b1;
    // stop check also fires on the start tick when run time is zero
    if (sec_cnt >= run_reg) begin
      motor_on = 1'b0;
      sec_cnt = '0;
      duty_cur = '0;
    end
    return {duty_cur, motor_on, led_cur, sec_cnt};
  endfunction

  // sender: hold a request until taken, otherwise offer the next tick or idle
  always @(posedge clk) begin : tick_driver
    bit offer;
    if (!rst_n) begin
      tick_valid <= 1'b0;
    end else begin
      if (tick_valid && in_ch.ready) begin
        expected_outs.push_back(advance_motor(tick_bus));
        void'(pending_ticks.pop_front());
      end
      if (!(tick_valid && !in_ch.ready)) begin
        offer = pending_ticks.size() != 0 && (steady || $urandom_range(99) >= 25);
        tick_valid <= offer;
        if (offer) tick_bus <= pending_ticks[0];
      end
    end
  end

  // receiver: random stalls, plus two long hold-offs so the block backs up
  always @(posedge clk) begin : result_taker
    if (!rst_n) begin
      take_ready <= 1'b0;
    end else if (hold_left > 0) begin
      take_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (out_ch.valid && take_ready &&
                 (results_taken == 249 || results_taken == 649)) begin
      take_ready <= 1'b0;
      hold_left <= 150;
    end else begin
      take_ready <= steady || $urandom_range(99) >= 25;
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin : result_checker
    motor_out_t got;
    motor_out_t want;
    if (rst_n && out_ch.valid && take_ready) begin
      results_taken <= results_taken + 1;
      got = {out_ch.pwm_duty, out_ch.pwm_enable, out_ch.led_level, out_ch.seconds_run};
      if (expected_outs.size() == 0) begin
        if (bad_count < 10)
          $display("%0t: result with no request pending: duty %0d en %0d led %0d secs %0d",
                   $time, got.duty, got.enable, got.led, got.secs);
        bad_count++;
      end else begin
        want = expected_outs.pop_front();
        if (got.duty !== want.duty || got.enable !== want.enable ||
            got.led !== want.led || got.secs !== want.secs) begin
          if (bad_count < 10)
            $display("%0t: mismatch exp/act duty %0d/%0d en %0d/%0d led %0d/%0d secs %0d/%0d",
                     $time, want.duty, got.duty, want.enable, got.enable,
                     want.led, got.led, want.secs, got.secs);
          bad_count++;
        end
      end
    end
  end

  // wait until every request is taken and answered, then let the pipe drain
  task automatic settle();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || expected_outs.size() != 0 || tick_valid);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_LOAD_THRESHOLD: thr_reg = val[SampleW-1:0];
      REG_RUN_SECONDS:    run_reg = val[CountW-1:0];
      REG_LEVEL_BOUNDS:   bounds_reg = val;
      REG_DUTY_STEPS:     duties_reg = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_tick(int t, int l);
    pending_ticks.push_back({SampleW'(t), SampleW'(l)});
  endtask

  // random setting per phase, extremes and a plain ramp mixed in
  task automatic pick_random_setup();
    logic [CfgDataW-1:0] v;
    logic [SampleW-1:0]  b [4];
    logic [SampleW-1:0]  tmp;
    int                  i;
    int                  j;
    int                  sel;
    sel = $urandom_range(9);
    if (sel == 0) v = 0;
    else if (sel == 1) v = 1023;
    else if (sel < 5) v = 200;
    else v = CfgDataW'({$urandom, $urandom});
    write_reg(REG_LOAD_THRESHOLD, v);

    // mostly short runs so stops come often
    sel = $urandom_range(19);
    if (sel == 0) v = 0;
    else if (sel < 15) v = CfgDataW'($urandom_range(30, 1));
    else if (sel < 19) v = CfgDataW'($urandom_range(200, 31));
    else v = CfgDataW'({$urandom, $urandom});
    write_reg(REG_RUN_SECONDS, v);

    if ($urandom_range(3) == 0) begin
      v = CfgDataW'({$urandom, $urandom});
    end else begin
      for (i = 0; i < 4; i++) b[i] = SampleW'($urandom_range(1023));
      for (i = 0; i < 3; i++)
        for (j = 0; j < 3 - i; j++)
          if (b[j] > b[j+1]) begin
            tmp = b[j];
            b[j] = b[j+1];
            b[j+1] = tmp;
          end
      v = {b[3], b[2], b[1], b[0]};
    end
    write_reg(REG_LEVEL_BOUNDS, v);
    write_reg(REG_DUTY_STEPS, CfgDataW'({$urandom, $urandom}));
  endtask

  // loads mostly around the threshold, time samples often next to a bound
  task automatic queue_random_ticks(int count);
    int i;
    int t;
    int l;
    int k;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(99) < 35 && thr_reg != 0) l = $urandom_range(int'(thr_reg) - 1);
      else if ($urandom_range(99) < 15) l = int'(thr_reg);
      else l = $urandom_range(1023, int'(thr_reg));
      if ($urandom_range(99) < 30) begin
        k = $urandom_range(3);
        t = int'(bounds_reg[10*k +: 10]) + int'($urandom_range(2)) - 1;
        if (t < 0) t = 0;
        if (t > 1023) t = 1023;
      end else begin
        t = $urandom_range(1023);
      end
      push_tick(t, l);
    end
  endtask

  initial begin : stimulus
    int total;
    int n;
    int phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: every level edge while idle, then a start on the top level
    @(negedge clk);
    push_tick(0, 1023);
    push_tick(519, 1023);
    push_tick(520, 1023);
    push_tick(649, 1023);
    push_tick(650, 1000);
    push_tick(759, 300);
    push_tick(760, 200);
    push_tick(939, 1023);
    push_tick(940, 1023);
    push_tick(1023, 199);
    push_tick(5, 5);
    push_tick(6, 6);
    push_tick(7, 7);
    settle();

    // zero run time: stop while running, then start and stop on one tick
    write_reg(REG_RUN_SECONDS, 0);
    @(negedge clk);
    push_tick(1, 2);
    push_tick(500, 0);
    settle();

    // bounds out of order, threshold zero never starts, longest run time
    write_reg(REG_LOAD_THRESHOLD, 0);
    write_reg(REG_RUN_SECONDS, CfgDataW'(16'hffff));
    write_reg(REG_LEVEL_BOUNDS, {10'd1023, 10'd0, 10'd300, 10'd600});
    write_reg(REG_DUTY_STEPS, '0);
    @(negedge clk);
    push_tick(599, 0);
    push_tick(600, 0);
    push_tick(1023, 0);
    settle();

    // all bounds at max, full duty, top threshold
    write_reg(REG_LOAD_THRESHOLD, 1023);
    write_reg(REG_LEVEL_BOUNDS, '1);
    write_reg(REG_DUTY_STEPS, '1);
    @(negedge clk);
    push_tick(1023, 1023);
    push_tick(1022, 1022);
    push_tick(0, 0);
    push_tick(1023, 1023);
    settle();

    // run time lowered below the count, then a one second run
    write_reg(REG_RUN_SECONDS, 1);
    @(negedge clk);
    push_tick(9, 9);
    push_tick(0, 0);
    push_tick(0, 0);
    settle();

    // random phases, one of them with no idling on either side
    total = 0;
    phase = 0;
    while (total < 950) begin
      pick_random_setup();
      steady = (phase == 4);
      n = $urandom_range(110, 60);
      @(negedge clk);
      queue_random_ticks(n);
      total += n;
      phase++;
      settle();
    end

    if (bad_count == 0 && expected_outs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: motor_soft_start_sequencer_core.f
src/mss_pkg.sv
src/mss_if.sv
src/mss_cfg_regs.sv
src/mss_step_logic.sv
src/motor_soft_start_sequencer_core.sv
tb/tb_motor_soft_start_sequencer_core.sv
